@@ design/llcp_pkg.sv @@
// llcp_pkg: shared widths, item types and latency figures for the
// line-line closest point pipeline; no dependencies
package llcp_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int LIMIT_W   = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd66;

  // exact intermediate widths
  localparam int DIFF_W    = COORD_W + 1;
  localparam int DOT_W     = 2 * DIFF_W + 1;
  localparam int NUM_W     = 2 * DOT_W;

  // digit-serial multiplier
  localparam int MUL_A_W    = NUM_W;
  localparam int MUL_B_W    = DOT_W;
  localparam int MUL_DIG_W  = 8;
  localparam int MUL_DIGITS = (MUL_B_W + MUL_DIG_W - 1) / MUL_DIG_W;
  localparam int MUL_BM_W   = MUL_DIGITS * MUL_DIG_W;
  localparam int MUL_P_W    = MUL_A_W + MUL_BM_W;
  localparam int MUL_LAT    = MUL_DIGITS + 2;

  // bit-per-stage divider
  localparam int DIV_N_W   = NUM_W + DIFF_W;
  localparam int DIV_D_W   = NUM_W;
  localparam int DIV_QB    = COORD_W + 2;
  localparam int DIV_Q_W   = DIV_QB + 2;
  localparam int DIV_LAT   = DIV_QB + 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic signed [NUM_W-1:0]   num_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_start_z;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t a_end_z;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_start_z;
    coord_t b_end_x;
    coord_t b_end_y;
    coord_t b_end_z;
  } llcp_in_t;

  typedef struct packed {
    logic   found;
    coord_t near_a_x;
    coord_t near_a_y;
    coord_t near_a_z;
    coord_t near_b_x;
    coord_t near_b_y;
    coord_t near_b_z;
    coord_t param_a;
    coord_t param_b;
  } llcp_out_t;

  // side data that rides along the whole pipe
  typedef struct packed {
    logic              bad;
    coord_t [2:0]      a_start;
    coord_t [2:0]      b_start;
    diff_t  [2:0]      d21;
    diff_t  [2:0]      d43;
  } llcp_ctx_t;

endpackage

@@ design/llcp_mul.sv @@
// llcp_mul: pipelined signed multiplier, one 8-bit digit of b per stage
// depends on llcp_pkg
module llcp_mul
  import llcp_pkg::*;
(
  input  logic                       clk_i,
  input  logic signed [MUL_A_W-1:0]  a_i,
  input  logic signed [MUL_B_W-1:0]  b_i,
  output logic signed [MUL_P_W-1:0]  p_o
);

  logic [MUL_A_W-1:0]  am_q  [MUL_DIGITS];
  logic [MUL_BM_W-1:0] bm_q  [MUL_DIGITS];
  logic [MUL_P_W-1:0]  acc_q [MUL_DIGITS+1];
  logic                sn_q  [MUL_DIGITS+1];
  logic signed [MUL_P_W-1:0] p_q;
  logic [MUL_A_W-1:0]  a_mag;
  logic [MUL_B_W-1:0]  b_mag;

  always_comb begin
    a_mag = a_i[MUL_A_W-1] ? MUL_A_W'(-a_i) : MUL_A_W'(a_i);
    b_mag = b_i[MUL_B_W-1] ? MUL_B_W'(-b_i) : MUL_B_W'(b_i);
  end

  always_ff @(posedge clk_i) begin
    am_q[0]  <= a_mag;
    bm_q[0]  <= MUL_BM_W'(b_mag);
    acc_q[0] <= '0;
    sn_q[0]  <= a_i[MUL_A_W-1] ^ b_i[MUL_B_W-1];
  end

  for (genvar k = 0; k < MUL_DIGITS; k++) begin : g_dig
    logic [MUL_A_W+MUL_DIG_W-1:0] pp;
    assign pp = am_q[k] * bm_q[k][MUL_DIG_W-1:0];
    always_ff @(posedge clk_i) begin
      acc_q[k+1] <= acc_q[k] + (MUL_P_W'(pp) << (k * MUL_DIG_W));
      sn_q[k+1]  <= sn_q[k];
    end
    if (k < MUL_DIGITS - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        am_q[k+1] <= am_q[k];
        bm_q[k+1] <= bm_q[k] >> MUL_DIG_W;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= sn_q[MUL_DIGITS] ? -$signed(acc_q[MUL_DIGITS]) : $signed(acc_q[MUL_DIGITS]);
  end

  assign p_o = p_q;

endmodule

@@ design/llcp_div.sv @@
// llcp_div: pipelined restoring divider, one quotient bit per stage,
// rounds to nearest with ties away from zero; depends on llcp_pkg
module llcp_div
  import llcp_pkg::*;
(
  input  logic                       clk_i,
  input  logic signed [DIV_N_W-1:0]  n_i,
  input  logic signed [DIV_D_W-1:0]  d_i,
  output logic signed [DIV_Q_W-1:0]  q_o
);

  logic [DIV_N_W-1:0] nm_q;
  logic [DIV_D_W-1:0] dm0_q;
  logic               sn0_q;
  logic [DIV_D_W-1:0] r_q   [DIV_QB+1];
  logic [DIV_D_W-1:0] dm_q  [DIV_QB+1];
  logic [DIV_QB-1:0]  qq_q  [DIV_QB+1];
  logic [DIV_QB-1:0]  nlo_q [DIV_QB];
  logic               ovf_q [DIV_QB+1];
  logic               sn_q  [DIV_QB+1];
  logic signed [DIV_Q_W-1:0] q_q;
  logic               rnd;
  logic [DIV_QB:0]    mag;
  logic [DIV_Q_W-1:0] q_mag;

  always_ff @(posedge clk_i) begin
    nm_q  <= n_i[DIV_N_W-1] ? DIV_N_W'(-n_i) : DIV_N_W'(n_i);
    dm0_q <= d_i[DIV_D_W-1] ? DIV_D_W'(-d_i) : DIV_D_W'(d_i);
    sn0_q <= n_i[DIV_N_W-1] ^ d_i[DIV_D_W-1];
  end

  // quotient too big for the field: clamp, outputs saturate anyway
  always_ff @(posedge clk_i) begin
    r_q[0]   <= DIV_D_W'(nm_q >> DIV_QB);
    nlo_q[0] <= nm_q[DIV_QB-1:0];
    qq_q[0]  <= '0;
    ovf_q[0] <= (nm_q >> DIV_QB) >= DIV_N_W'(dm0_q);
    dm_q[0]  <= dm0_q;
    sn_q[0]  <= sn0_q;
  end

  for (genvar k = 0; k < DIV_QB; k++) begin : g_bit
    logic [DIV_D_W:0] r2;
    logic             ge;
    assign r2 = {r_q[k], nlo_q[k][DIV_QB-1]};
    assign ge = r2 >= {1'b0, dm_q[k]};
    always_ff @(posedge clk_i) begin
      r_q[k+1]   <= ge ? DIV_D_W'(r2 - {1'b0, dm_q[k]}) : DIV_D_W'(r2);
      qq_q[k+1]  <= {qq_q[k][DIV_QB-2:0], ge};
      dm_q[k+1]  <= dm_q[k];
      ovf_q[k+1] <= ovf_q[k];
      sn_q[k+1]  <= sn_q[k];
    end
    if (k < DIV_QB - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        nlo_q[k+1] <= nlo_q[k] << 1;
      end
    end
  end

  always_comb begin
    rnd   = {r_q[DIV_QB], 1'b0} >= {1'b0, dm_q[DIV_QB]};
    mag   = ovf_q[DIV_QB] ? ((DIV_QB+1)'(1) << DIV_QB)
                          : (DIV_QB+1)'(qq_q[DIV_QB]) + (DIV_QB+1)'(rnd);
    q_mag = DIV_Q_W'(mag);
  end

  always_ff @(posedge clk_i) begin
    q_q <= sn_q[DIV_QB] ? -$signed(q_mag) : $signed(q_mag);
  end

  assign q_o = q_q;

endmodule

@@ design/line_line_closest_points_top.sv @@
// line_line_closest_points_top: closest points between two 3d lines,
// fully pipelined; depends on llcp_pkg, llcp_mul, llcp_div
//
//   port group            dir  meaning
//   start_i / busy_o      in   item handshake, taken when start_i && !busy_o
//   in_item_i             in   two lines, two points each, signed q16.16
//   res_valid_o / res_o   out  one-cycle strobe with the result item
//   cfg_we_i/cfg_wdata_i  in   near-zero limit write, q0.16
//
// one item enters every cycle; busy_o is never raised
// the result strobe follows the accepting edge through three chained pipelined
// multipliers and the bit-per-stage divider
// reset clears the valid bits and loads the limit register
// the receiver cannot stall, so the pipe never holds and nothing is lost
module line_line_closest_points_top
  import llcp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  llcp_in_t             in_item_i,
  output logic                 res_valid_o,
  output llcp_out_t            res_o,
  input  logic                 cfg_we_i,
  input  logic [LIMIT_W-1:0]   cfg_wdata_i
);

  // ctx index where each piece of work sits
  localparam int I_DOT   = MUL_LAT + 1;
  localparam int I_NUM   = I_DOT + MUL_LAT + 1;
  localparam int I_DIV   = I_NUM + MUL_LAT;
  localparam int I_OUT   = I_DIV + DIV_LAT;
  localparam int LATENCY = I_OUT + 2;
  localparam int N_MUL   = 27;
  localparam int N_DIV   = 8;

  logic [LIMIT_W-1:0] lim_q;
  logic               vld_q [I_OUT+1];
  llcp_ctx_t          ctx_q [I_OUT+1];
  llcp_ctx_t          ctx_d [I_OUT+1];
  llcp_ctx_t          ctx_in;
  diff_t [2:0]        d13_d;
  diff_t [2:0]        d13_q;
  dot_t               dot_q [5];
  num_t               denom_q, numa_q, numb_q;
  num_t               pna_q [MUL_LAT];
  num_t               pnb_q [MUL_LAT];
  num_t               pdn_q [MUL_LAT];
  logic signed [MUL_A_W-1:0] mul_a [N_MUL];
  logic signed [MUL_B_W-1:0] mul_b [N_MUL];
  logic signed [MUL_P_W-1:0] mul_p [N_MUL];
  logic signed [DIV_N_W-1:0] div_n [N_DIV];
  logic signed [DIV_Q_W-1:0] div_q [N_DIV];
  logic               res_valid_q;
  llcp_out_t          res_q;
  llcp_out_t          res_d;
  logic               accept;

  function automatic logic all_small(input diff_t [2:0] v, input logic [LIMIT_W-1:0] lim);
    logic r;
    logic [DIFF_W-1:0] m;
    r = 1'b1;
    for (int k = 0; k < 3; k++) begin
      m = v[k][DIFF_W-1] ? DIFF_W'(-v[k]) : DIFF_W'(v[k]);
      if (m >= DIFF_W'(lim)) r = 1'b0;
    end
    return r;
  endfunction

  function automatic coord_t sat(input logic signed [DIV_Q_W:0] v);
    logic signed [DIV_Q_W:0] hi, lo;
    hi = (DIV_Q_W+1)'($signed({1'b0, {(COORD_W-1){1'b1}}}));
    lo = -hi - (DIV_Q_W+1)'(1);
    if (v > hi) return coord_t'(hi);
    if (v < lo) return coord_t'(lo);
    return coord_t'(v);
  endfunction

  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;

  // near-zero limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      lim_q <= cfg_wdata_i;
    end
  end

  // entry stage: point differences
  always_comb begin
    ctx_in.bad = 1'b0;
    ctx_in.a_start = {in_item_i.a_start_z, in_item_i.a_start_y, in_item_i.a_start_x};
    ctx_in.b_start = {in_item_i.b_start_z, in_item_i.b_start_y, in_item_i.b_start_x};
    ctx_in.d21[0] = diff_t'(in_item_i.a_end_x) - diff_t'(in_item_i.a_start_x);
    ctx_in.d21[1] = diff_t'(in_item_i.a_end_y) - diff_t'(in_item_i.a_start_y);
    ctx_in.d21[2] = diff_t'(in_item_i.a_end_z) - diff_t'(in_item_i.a_start_z);
    ctx_in.d43[0] = diff_t'(in_item_i.b_end_x) - diff_t'(in_item_i.b_start_x);
    ctx_in.d43[1] = diff_t'(in_item_i.b_end_y) - diff_t'(in_item_i.b_start_y);
    ctx_in.d43[2] = diff_t'(in_item_i.b_end_z) - diff_t'(in_item_i.b_start_z);
    d13_d[0] = diff_t'(in_item_i.a_start_x) - diff_t'(in_item_i.b_start_x);
    d13_d[1] = diff_t'(in_item_i.a_start_y) - diff_t'(in_item_i.b_start_y);
    d13_d[2] = diff_t'(in_item_i.a_start_z) - diff_t'(in_item_i.b_start_z);
  end

  // side-data line, with the two rejection checks folded in
  always_comb begin
    ctx_d[0] = ctx_in;
    for (int i = 1; i <= I_OUT; i++) begin
      ctx_d[i] = ctx_q[i-1];
    end
    // degenerate direction on either line
    ctx_d[1].bad = all_small(ctx_q[0].d21, lim_q) || all_small(ctx_q[0].d43, lim_q);
    // near-parallel lines, zero denominator included
    ctx_d[I_NUM+1].bad = ctx_q[I_NUM].bad || denom_q[NUM_W-1] || (denom_q == '0) ||
                         (NUM_W'(denom_q) < (NUM_W'(lim_q) << (3 * FRAC_W)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= I_OUT; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
      for (int i = 1; i <= I_OUT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i <= I_OUT; i++) ctx_q[i] <= ctx_d[i];
    d13_q <= d13_d;
  end

  // multiplier operands: 15 dot terms, 6 cross terms, 6 coordinate numerators
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mul_a[k]      = MUL_A_W'(d13_q[k]);          mul_b[k]      = MUL_B_W'(ctx_q[0].d43[k]);
      mul_a[3 + k]  = MUL_A_W'(ctx_q[0].d43[k]);   mul_b[3 + k]  = MUL_B_W'(ctx_q[0].d21[k]);
      mul_a[6 + k]  = MUL_A_W'(d13_q[k]);          mul_b[6 + k]  = MUL_B_W'(ctx_q[0].d21[k]);
      mul_a[9 + k]  = MUL_A_W'(ctx_q[0].d43[k]);   mul_b[9 + k]  = MUL_B_W'(ctx_q[0].d43[k]);
      mul_a[12 + k] = MUL_A_W'(ctx_q[0].d21[k]);   mul_b[12 + k] = MUL_B_W'(ctx_q[0].d21[k]);
      mul_a[21 + k] = MUL_A_W'(numa_q);            mul_b[21 + k] = MUL_B_W'(ctx_q[I_NUM].d21[k]);
      mul_a[24 + k] = MUL_A_W'(numb_q);            mul_b[24 + k] = MUL_B_W'(ctx_q[I_NUM].d43[k]);
    end
    // dot order: 1343, 4321, 1321, 4343, 2121
    mul_a[15] = MUL_A_W'(dot_q[4]); mul_b[15] = dot_q[3];
    mul_a[16] = MUL_A_W'(dot_q[1]); mul_b[16] = dot_q[1];
    mul_a[17] = MUL_A_W'(dot_q[0]); mul_b[17] = dot_q[1];
    mul_a[18] = MUL_A_W'(dot_q[2]); mul_b[18] = dot_q[3];
    mul_a[19] = MUL_A_W'(dot_q[0]); mul_b[19] = dot_q[4];
    mul_a[20] = MUL_A_W'(dot_q[1]); mul_b[20] = dot_q[2];
  end

  for (genvar m = 0; m < N_MUL; m++) begin : g_mul
    llcp_mul u_mul (
      .clk_i (clk_i),
      .a_i   (mul_a[m]),
      .b_i   (mul_b[m]),
      .p_o   (mul_p[m])
    );
  end

  // dot sums, then denominator and numerators
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 5; j++) begin
      dot_q[j] <= DOT_W'(mul_p[3*j]) + DOT_W'(mul_p[3*j+1]) + DOT_W'(mul_p[3*j+2]);
    end
    denom_q <= NUM_W'(mul_p[15]) - NUM_W'(mul_p[16]);
    numa_q  <= NUM_W'(mul_p[17]) - NUM_W'(mul_p[18]);
    numb_q  <= NUM_W'(mul_p[19]) - NUM_W'(mul_p[20]);
    pna_q[0] <= numa_q;
    pnb_q[0] <= numb_q;
    pdn_q[0] <= denom_q;
    for (int j = 1; j < MUL_LAT; j++) begin
      pna_q[j] <= pna_q[j-1];
      pnb_q[j] <= pnb_q[j-1];
      pdn_q[j] <= pdn_q[j-1];
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      div_n[k] = $signed(mul_p[21 + k][DIV_N_W-1:0]);
    end
    div_n[6] = DIV_N_W'(pna_q[MUL_LAT-1]) <<< FRAC_W;
    div_n[7] = DIV_N_W'(pnb_q[MUL_LAT-1]) <<< FRAC_W;
  end

  for (genvar q = 0; q < N_DIV; q++) begin : g_div
    llcp_div u_div (
      .clk_i (clk_i),
      .n_i   (div_n[q]),
      .d_i   (DIV_D_W'(pdn_q[MUL_LAT-1])),
      .q_o   (div_q[q])
    );
  end

  // final add to the start points and saturation
  always_comb begin
    res_d = '0;
    if (!ctx_q[I_OUT].bad) begin
      res_d.found    = 1'b1;
      res_d.near_a_x = sat((DIV_Q_W+1)'(ctx_q[I_OUT].a_start[0]) + (DIV_Q_W+1)'(div_q[0]));
      res_d.near_a_y = sat((DIV_Q_W+1)'(ctx_q[I_OUT].a_start[1]) + (DIV_Q_W+1)'(div_q[1]));
      res_d.near_a_z = sat((DIV_Q_W+1)'(ctx_q[I_OUT].a_start[2]) + (DIV_Q_W+1)'(div_q[2]));
      res_d.near_b_x = sat((DIV_Q_W+1)'(ctx_q[I_OUT].b_start[0]) + (DIV_Q_W+1)'(div_q[3]));
      res_d.near_b_y = sat((DIV_Q_W+1)'(ctx_q[I_OUT].b_start[1]) + (DIV_Q_W+1)'(div_q[4]));
      res_d.near_b_z = sat((DIV_Q_W+1)'(ctx_q[I_OUT].b_start[2]) + (DIV_Q_W+1)'(div_q[5]));
      res_d.param_a  = sat((DIV_Q_W+1)'(div_q[6]));
      res_d.param_b  = sat((DIV_Q_W+1)'(div_q[7]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= vld_q[I_OUT];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // every item comes out after the fixed latency, and only then
  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY res_valid_o)
    else $error("item lost in pipeline");

  a_latency_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(accept, LATENCY))
    else $error("result without item");

  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.found) |-> (res_o.param_a == '0 && res_o.param_b == '0 &&
      res_o.near_a_x == '0 && res_o.near_b_x == '0))
    else $error("rejected result not cleared");

endmodule
